// File: rtl/amgs_pkg.sv
// Shared types and codes for the adjacency matrix graph store.
`default_nettype none

package amgs_pkg;

    // Index fields in the cell command are wide enough for the largest store.
    localparam int IDX_W = 6;
    // Compare width for indices against the vertex count.
    localparam int CMP_W = 7;
    localparam int VAL_W = 32;

    typedef enum logic [2:0] {
        OP_ADD_VERTEX = 3'd0,
        OP_ADD_EDGE   = 3'd1,
        OP_REM_VERTEX = 3'd2,
        OP_REM_EDGE   = 3'd3,
        OP_READ       = 3'd4
    } op_t;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_SAME  = 2'd2;
    localparam logic [1:0] ERR_FULL  = 2'd3;

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_ADD_VERTEX = 3'd1,
        CMD_ADD_EDGE   = 3'd2,
        CMD_REM_EDGE   = 3'd3,
        CMD_REM_VERTEX = 3'd4
    } cmd_kind_t;

    // Broadcast to every cell; kind is CMD_NONE unless a valid update is taken.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [IDX_W-1:0]  idx_a;
        logic [IDX_W-1:0]  idx_b;
        logic [IDX_W-1:0]  idx_total;
        logic [VAL_W-1:0]  value;
    } cmd_t;

endpackage

`default_nettype wire

// File: rtl/amgs_cell.sv
// One vertex slot: its stored value and adjacency row, fed from the slot above.
`default_nettype none

module amgs_cell #(
    parameter int MAX_VERTICES = 16,
    parameter int CELL_INDEX   = 0
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire amgs_pkg::cmd_t              cmd,
    input  wire logic [amgs_pkg::VAL_W-1:0]  up_value,
    input  wire logic [MAX_VERTICES-1:0]     up_row,
    output logic      [amgs_pkg::VAL_W-1:0]  value_q,
    output logic      [MAX_VERTICES-1:0]     row_q
);

    localparam logic [amgs_pkg::IDX_W-1:0] SELF = amgs_pkg::IDX_W'(CELL_INDEX);

    logic [amgs_pkg::VAL_W-1:0] value_reg;
    logic [amgs_pkg::VAL_W-1:0] value_next;
    logic [MAX_VERTICES-1:0]    row_reg;
    logic [MAX_VERTICES-1:0]    row_next;
    logic [MAX_VERTICES-1:0]    onehot_a;
    logic [MAX_VERTICES-1:0]    onehot_b;
    logic [MAX_VERTICES-1:0]    onehot_total;
    logic [MAX_VERTICES-1:0]    below_a;
    logic [MAX_VERTICES-1:0]    src_row;
    logic [amgs_pkg::VAL_W-1:0] src_value;

    always_comb begin
        for (int j = 0; j < MAX_VERTICES; j++) begin
            onehot_a[j]     = (cmd.idx_a == amgs_pkg::IDX_W'(j));
            onehot_b[j]     = (cmd.idx_b == amgs_pkg::IDX_W'(j));
            onehot_total[j] = (cmd.idx_total == amgs_pkg::IDX_W'(j));
            below_a[j]      = (amgs_pkg::IDX_W'(j) < cmd.idx_a);
        end
    end

    // On a vertex removal every slot at or above the removed one takes its
    // upper neighbor, then the removed column is squeezed out of each row.
    assign src_row   = (SELF >= cmd.idx_a) ? up_row : row_reg;
    assign src_value = (SELF >= cmd.idx_a) ? up_value : value_reg;

    always_comb begin
        row_next   = row_reg;
        value_next = value_reg;
        unique case (cmd.kind)
            amgs_pkg::CMD_ADD_VERTEX: begin
                if (SELF == cmd.idx_total) begin
                    value_next = cmd.value;
                    row_next   = '0;
                end else begin
                    row_next = row_reg & ~onehot_total;
                end
            end
            amgs_pkg::CMD_ADD_EDGE: begin
                if (SELF == cmd.idx_a) row_next = row_next | onehot_b;
                if (SELF == cmd.idx_b) row_next = row_next | onehot_a;
            end
            amgs_pkg::CMD_REM_EDGE: begin
                if (SELF == cmd.idx_a) row_next = row_next & ~onehot_b;
                if (SELF == cmd.idx_b) row_next = row_next & ~onehot_a;
            end
            amgs_pkg::CMD_REM_VERTEX: begin
                value_next = src_value;
                row_next   = (src_row & below_a) | ((src_row >> 1) & ~below_a);
            end
            default: begin
                row_next   = row_reg;
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else begin
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value_q = value_reg;
    assign row_q   = row_reg;

endmodule

`default_nettype wire

// File: rtl/adjacency_matrix_graph_store.sv
// Top level of the adjacency matrix graph store: request decode, checks and result register.
// Latency: a request's result is registered at the edge that accepts it and is shown
// the next cycle. Throughput: one request per cycle while m_ready is high; every
// operation, including removal with compaction, finishes at the edge that accepts it because
// each cell updates its own row in parallel. Reset clears the vertex count, all
// adjacency rows and the result valid; stored vertex values are left as they are.
`default_nettype none

module adjacency_matrix_graph_store #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_op,
    input  wire logic signed [31:0] s_vertex_value,
    input  wire logic [3:0]         s_index_a,
    input  wire logic [3:0]         s_index_b,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_error_code,
    output logic [4:0]              m_vertex_count,
    output logic signed [31:0]      m_read_value,
    output logic [15:0]             m_adjacency_row
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic [CNT_W-1:0]              total_reg;
    logic [CNT_W-1:0]              total_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [1:0]                    err_reg;
    logic [1:0]                    err_next;
    logic [4:0]                    count_reg;
    logic [31:0]                   rval_reg;
    logic [31:0]                   rval_next;
    logic [15:0]                   rrow_reg;
    logic [15:0]                   rrow_next;
    logic                          accept;
    logic                          a_ok;
    logic                          b_ok;
    logic                          full;
    logic [amgs_pkg::CMP_W-1:0]    total_w;
    logic [31:0]                   sel_value;
    logic [MAX_VERTICES-1:0]       sel_row;
    amgs_pkg::cmd_t                cmd;
    amgs_pkg::cmd_kind_t           kind;

    logic [amgs_pkg::VAL_W-1:0]    value_q [MAX_VERTICES+1];
    logic [MAX_VERTICES-1:0]       row_q   [MAX_VERTICES+1];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign total_w = amgs_pkg::CMP_W'(total_reg);
    assign a_ok    = (amgs_pkg::CMP_W'(s_index_a) < total_w);
    assign b_ok    = (amgs_pkg::CMP_W'(s_index_b) < total_w);
    assign full    = (total_reg == CNT_W'(MAX_VERTICES));

    // Read port: and-or select of the addressed cell, valid only below the count.
    always_comb begin
        sel_value = '0;
        sel_row   = '0;
        for (int j = 0; j < MAX_VERTICES; j++) begin
            if (amgs_pkg::IDX_W'(j) == amgs_pkg::IDX_W'(s_index_a)) begin
                sel_value = sel_value | value_q[j];
                sel_row   = sel_row | row_q[j];
            end
        end
    end

    always_comb begin
        err_next   = amgs_pkg::ERR_OK;
        total_next = total_reg;
        kind       = amgs_pkg::CMD_NONE;
        rval_next  = '0;
        rrow_next  = '0;
        unique case (amgs_pkg::op_t'(s_op))
            amgs_pkg::OP_ADD_VERTEX: begin
                if (full) begin
                    err_next = amgs_pkg::ERR_FULL;
                end else begin
                    kind       = amgs_pkg::CMD_ADD_VERTEX;
                    total_next = total_reg + CNT_W'(1);
                end
            end
            amgs_pkg::OP_ADD_EDGE, amgs_pkg::OP_REM_EDGE: begin
                if (!a_ok || !b_ok) begin
                    err_next = amgs_pkg::ERR_RANGE;
                end else if (s_index_a == s_index_b) begin
                    err_next = amgs_pkg::ERR_SAME;
                end else if (amgs_pkg::op_t'(s_op) == amgs_pkg::OP_ADD_EDGE) begin
                    kind = amgs_pkg::CMD_ADD_EDGE;
                end else begin
                    kind = amgs_pkg::CMD_REM_EDGE;
                end
            end
            amgs_pkg::OP_REM_VERTEX: begin
                if (!a_ok) begin
                    err_next = amgs_pkg::ERR_RANGE;
                end else begin
                    kind       = amgs_pkg::CMD_REM_VERTEX;
                    total_next = total_reg - CNT_W'(1);
                end
            end
            amgs_pkg::OP_READ: begin
                if (!a_ok) begin
                    err_next = amgs_pkg::ERR_RANGE;
                end else begin
                    rval_next = sel_value;
                    rrow_next = 16'(sel_row);
                end
            end
            default: begin
                err_next = amgs_pkg::ERR_OK;
            end
        endcase
    end

    always_comb begin
        cmd.kind      = accept ? kind : amgs_pkg::CMD_NONE;
        cmd.idx_a     = amgs_pkg::IDX_W'(s_index_a);
        cmd.idx_b     = amgs_pkg::IDX_W'(s_index_b);
        cmd.idx_total = amgs_pkg::IDX_W'(total_reg);
        cmd.value     = s_vertex_value;
    end

    assign value_q[MAX_VERTICES] = '0;
    assign row_q[MAX_VERTICES]   = '0;

    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
        amgs_cell #(
            .MAX_VERTICES (MAX_VERTICES),
            .CELL_INDEX   (g)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .up_value (value_q[g+1]),
            .up_row   (row_q[g+1]),
            .value_q  (value_q[g]),
            .row_q    (row_q[g])
        );
    end

    assign m_valid_next = accept ? 1'b1 : (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            err_reg   <= err_next;
            count_reg <= 5'(total_next);
            rval_reg  <= rval_next;
            rrow_reg  <= rrow_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_error_code    = err_reg;
    assign m_vertex_count  = count_reg;
    assign m_read_value    = rval_reg;
    assign m_adjacency_row = rrow_reg;

    // The matrix must stay symmetric with an empty diagonal.
    logic sym_ok;
    always_comb begin
        sym_ok = 1'b1;
        for (int i = 0; i < MAX_VERTICES; i++) begin
            for (int j = 0; j < MAX_VERTICES; j++) begin
                if (row_q[i][j] != row_q[j][i]) sym_ok = 1'b0;
            end
            if (row_q[i][i]) sym_ok = 1'b0;
        end
    end

    a_symmetric: assert property (@(posedge aclk) disable iff (!aresetn) sym_ok)
        else $error("adjacency matrix lost symmetry");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count exceeds capacity");

    a_add_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_op == amgs_pkg::OP_ADD_VERTEX) && !full
        |=> total_reg == $past(total_reg) + CNT_W'(1))
        else $error("vertex add did not advance the count");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error_code == amgs_pkg::ERR_FULL)
        |-> m_vertex_count == 5'(MAX_VERTICES))
        else $error("full error reported below capacity");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vertex_count))
        else $error("stalled result changed");

endmodule

`default_nettype wire
